// ----- design/mcs_pkg.sv -----
// mcs_pkg: shared codes and types for the 16-bit processor step core
// no dependencies; every other design file imports it
`default_nettype none

package mcs_pkg;

    typedef logic [15:0] word_t;

    // request command codes
    localparam logic [2:0] CMD_LOAD  = 3'd0;
    localparam logic [2:0] CMD_EXEC  = 3'd1;
    localparam logic [2:0] CMD_RDREG = 3'd2;
    localparam logic [2:0] CMD_RDMEM = 3'd3;
    localparam logic [2:0] CMD_START = 3'd4;

    // response status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_HALTED  = 3'd2;
    localparam logic [2:0] ST_NOOP    = 3'd3;
    localparam logic [2:0] ST_MODE    = 3'd4;
    localparam logic [2:0] ST_ODD     = 3'd5;

    // datapath micro-operations
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_LATCH   = 5'd1;
    localparam logic [4:0] OP_LOAD    = 5'd2;
    localparam logic [4:0] OP_START   = 5'd3;
    localparam logic [4:0] OP_COPY    = 5'd4;
    localparam logic [4:0] OP_MAR_REQ = 5'd5;
    localparam logic [4:0] OP_RD_LO   = 5'd6;
    localparam logic [4:0] OP_RD_HI   = 5'd7;
    localparam logic [4:0] OP_RD_END  = 5'd8;
    localparam logic [4:0] OP_FETCH   = 5'd9;
    localparam logic [4:0] OP_OPND    = 5'd10;
    localparam logic [4:0] OP_DEFER   = 5'd11;
    localparam logic [4:0] OP_SETVAL  = 5'd12;
    localparam logic [4:0] OP_WB_LO   = 5'd13;
    localparam logic [4:0] OP_WB_HI   = 5'd14;
    localparam logic [4:0] OP_SOB     = 5'd15;
    localparam logic [4:0] OP_COMMIT  = 5'd16;
    localparam logic [4:0] OP_HALT    = 5'd17;
    localparam logic [4:0] OP_RESP    = 5'd18;

    // write-back value select
    localparam logic [1:0] ALU_MOV = 2'd0;
    localparam logic [1:0] ALU_ADD = 2'd1;
    localparam logic [1:0] ALU_CLR = 2'd2;

    // read data select for the response
    localparam logic [1:0] RSEL_ZERO = 2'd0;
    localparam logic [1:0] RSEL_REG  = 2'd1;
    localparam logic [1:0] RSEL_MDR  = 2'd2;

    localparam word_t RESET_START = 16'd512;

    typedef struct packed {
        logic [4:0] op;
        logic       dst;
        logic       byte_op;
        logic [1:0] alu;
        logic [2:0] status;
        logic [1:0] rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] req_cmd;
        logic       req_odd;
        logic       halted;
        logic       mar_odd;
        logic       dst_in_reg;
        logic       out_free;
        word_t      ir;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/mcs_if.sv -----
// mcs_req_if and mcs_rsp_if: valid/ready channels of the step core
// depends on mcs_pkg
`default_nettype none

interface mcs_req_if import mcs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    word_t      address;
    logic [7:0] load_byte;

    modport source (output valid, output cmd, output address, output load_byte, input ready);
    modport sink   (input valid, input cmd, input address, input load_byte, output ready);
endinterface

interface mcs_rsp_if import mcs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] status;
    word_t      program_counter;
    word_t      read_data;

    modport source (output valid, output status, output program_counter, output read_data,
                    input ready);
    modport sink   (input valid, input status, input program_counter, input read_data,
                    output ready);
endinterface

`default_nettype wire

// ----- design/minimal_16bit_cpu_step_core.sv -----
// channel  direction  handshake     payload
// req      in         valid/ready   cmd, address, load_byte
// rsp      out        valid/ready   status, program_counter, read_data
// cfg      in         cfg_wr_en     cfg_wr_data (start address)
//
// load, register read and start go from accept through dispatch to the response;
// a memory word read and an instruction add the memory accesses in between,
// made through the one byte-wide memory port (two accesses per word, fetch and operands)
// reset leaves R0-R7 zero, the core halted and start address 512; memory is unset
// a finished response waits in the output register until rsp.ready; the
// next request waits in the response state only while that register is full
// depends on mcs_pkg, mcs_if, mcs_datapath, mcs_controller
`default_nettype none

module minimal_16bit_cpu_step_core import mcs_pkg::*; #(
    parameter int MEMORY_BYTES = 65536
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mcs_req_if.sink    req,
    mcs_rsp_if.source  rsp,
    input  wire logic  cfg_wr_en,
    input  wire word_t cfg_wr_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer
    mcs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // registers, memory and response register
    mcs_datapath #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .req_cmd       (req.cmd),
        .req_address   (req.address),
        .req_load_byte (req.load_byte),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_status    (rsp.status),
        .rsp_pc        (rsp.program_counter),
        .rsp_data      (rsp.read_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

endmodule

`default_nettype wire

// ----- design/mcs_datapath.sv -----
// mcs_datapath: registers, byte memory, operand and write-back logic
// depends on mcs_pkg; driven by mcs_controller through dp_cmd_t
`default_nettype none

module mcs_datapath import mcs_pkg::*; #(
    parameter int MEMORY_BYTES = 65536
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    output dp_stat_t        stat,
    input  wire logic [2:0] req_cmd,
    input  wire word_t      req_address,
    input  wire logic [7:0] req_load_byte,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output logic [2:0]      rsp_status,
    output word_t           rsp_pc,
    output word_t           rsp_data,
    input  wire logic       cfg_wr_en,
    input  wire word_t      cfg_wr_data
);

    localparam int AW  = $clog2(MEMORY_BYTES);
    localparam int AW1 = AW + 1;
    localparam logic [AW:0] MEM_SIZE = AW1'(MEMORY_BYTES);

    logic [2:0]  req_cmd_reg;
    word_t       req_addr_reg;
    logic [7:0]  req_byte_reg;
    word_t       start_addr_reg;
    word_t       arch_reg [8];
    word_t       arch_next [8];
    word_t       work_reg [8];
    word_t       work_next [8];
    logic        halted_reg, halted_next;
    word_t       ir_reg, mar_reg, mdr_reg, src_val_reg, dst_val_reg;
    logic [7:0]  lo_reg;
    logic        dst_in_reg;
    logic [7:0]  rdata_reg;
    logic        rsp_valid_reg;
    logic [2:0]  rsp_status_reg;
    word_t       rsp_pc_reg, rsp_data_reg;

    logic [7:0]  mem [MEMORY_BYTES];
    logic [AW-1:0] blk_base [64];
    word_t       mem_addr;
    logic [AW:0] mem_sum;
    logic [AW-1:0] mem_idx;
    logic        mem_we, mem_re;
    logic [7:0]  mem_wdata;

    logic [5:0]  spec;
    logic [2:0]  mode, sreg, reg_idx;
    word_t       reg_val, step, wb_val, wb_reg_val, sob_dec, sob_off, opnd_val, mdr_val;

    // base offset of each 1 KiB block modulo the memory size
    for (genvar k = 0; k < 64; k++) begin : g_base
        localparam int unsigned BASE = (k * 1024) % MEMORY_BYTES;
        assign blk_base[k] = AW'(BASE);
    end

    // memory address select and reduction
    always_comb
    begin
        mem_addr  = mar_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = wb_val[7:0];
        case (cmd.op)
            OP_LOAD:
            begin
                mem_addr  = req_addr_reg;
                mem_we    = 1'b1;
                mem_wdata = req_byte_reg;
            end
            OP_RD_LO: mem_re = 1'b1;
            OP_RD_HI:
            begin
                mem_addr = {mar_reg[15:1], 1'b1};
                mem_re   = 1'b1;
            end
            OP_WB_LO: mem_we = !dst_in_reg;
            OP_WB_HI:
            begin
                mem_addr  = {mar_reg[15:1], 1'b1};
                mem_we    = 1'b1;
                mem_wdata = wb_val[15:8];
            end
            default: ;
        endcase
        mem_sum = {1'b0, blk_base[mem_addr[15:10]]} + AW1'(mem_addr[9:0]);
        mem_idx = (mem_sum >= MEM_SIZE) ? AW'(mem_sum - MEM_SIZE) : mem_sum[AW-1:0];
    end

    // byte memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_idx] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_idx];
    end

    // operand decode and arithmetic
    always_comb
    begin
        spec       = cmd.dst ? ir_reg[5:0] : ir_reg[11:6];
        mode       = spec[5:3];
        sreg       = spec[2:0];
        reg_idx    = (cmd.op == OP_SOB) ? ir_reg[8:6] : sreg;
        reg_val    = work_reg[reg_idx];
        step       = (cmd.byte_op && sreg < 3'd6) ? 16'd1 : 16'd2;
        if (mode == 3'd3 || mode == 3'd5)
            step = 16'd2;
        opnd_val   = cmd.byte_op ? {8'h00, reg_val[7:0]} : reg_val;
        mdr_val    = cmd.byte_op ? {8'h00, mdr_reg[7:0]} : mdr_reg;
        case (cmd.alu)
            ALU_ADD: wb_val = src_val_reg + dst_val_reg;
            ALU_CLR: wb_val = '0;
            default: wb_val = src_val_reg;
        endcase
        wb_reg_val = cmd.byte_op ? {{8{wb_val[7]}}, wb_val[7:0]} : wb_val;
        sob_dec    = reg_val - 16'd1;
        sob_off    = {9'd0, ir_reg[5:0], 1'b0};
    end

    // register file next values
    always_comb
    begin
        work_next   = work_reg;
        arch_next   = arch_reg;
        halted_next = halted_reg;
        case (cmd.op)
            OP_COPY:   work_next = arch_reg;
            OP_FETCH:  work_next[7] = work_reg[7] + 16'd2;
            OP_OPND:
            begin
                case (mode)
                    3'd2, 3'd3: work_next[sreg] = reg_val + step;
                    3'd4, 3'd5: work_next[sreg] = reg_val - step;
                    default: ;
                endcase
            end
            OP_WB_LO:
            begin
                if (dst_in_reg)
                    work_next[sreg] = wb_reg_val;
            end
            OP_SOB:
            begin
                work_next[reg_idx] = sob_dec;
                if (sob_dec != 16'd0)
                    work_next[7] = ((reg_idx == 3'd7) ? sob_dec : work_reg[7]) - sob_off;
            end
            OP_COMMIT: arch_next = work_reg;
            OP_START:
            begin
                arch_next[7] = start_addr_reg;
                halted_next  = 1'b0;
            end
            OP_HALT:   halted_next = 1'b1;
            default: ;
        endcase
    end

    // architectural state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                arch_reg[i] <= '0;
            halted_reg     <= 1'b1;
            start_addr_reg <= RESET_START;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            arch_reg   <= arch_next;
            halted_reg <= halted_next;
            if (cfg_wr_en)
                start_addr_reg <= cfg_wr_data;
            if (cmd.op == OP_RESP)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // working registers and payload
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        case (cmd.op)
            OP_LATCH:
            begin
                req_cmd_reg  <= req_cmd;
                req_addr_reg <= req_address;
                req_byte_reg <= req_load_byte;
            end
            OP_COPY:    mar_reg <= arch_reg[7];
            OP_MAR_REQ: mar_reg <= req_addr_reg;
            OP_RD_HI:   lo_reg  <= rdata_reg;
            OP_RD_END:  mdr_reg <= {rdata_reg, lo_reg};
            OP_FETCH:   ir_reg  <= mdr_reg;
            OP_OPND:
            begin
                case (mode)
                    3'd4, 3'd5: mar_reg <= reg_val - step;
                    default:    mar_reg <= reg_val;
                endcase
                if (cmd.dst)
                begin
                    dst_in_reg  <= (mode == 3'd0);
                    dst_val_reg <= opnd_val;
                end
                else
                    src_val_reg <= opnd_val;
            end
            OP_DEFER:   mar_reg <= mdr_reg;
            OP_SETVAL:
            begin
                if (cmd.dst)
                    dst_val_reg <= mdr_val;
                else
                    src_val_reg <= mdr_val;
            end
            OP_RESP:
            begin
                rsp_status_reg <= cmd.status;
                rsp_pc_reg     <= arch_reg[7];
                case (cmd.rd_sel)
                    RSEL_REG: rsp_data_reg <= arch_reg[req_addr_reg[2:0]];
                    RSEL_MDR: rsp_data_reg <= mdr_reg;
                    default:  rsp_data_reg <= '0;
                endcase
            end
            default: ;
        endcase
    end

    // status toward the controller
    always_comb
    begin
        stat.req_cmd    = req_cmd_reg;
        stat.req_odd    = req_addr_reg[0];
        stat.halted     = halted_reg;
        stat.mar_odd    = mar_reg[0];
        stat.dst_in_reg = dst_in_reg;
        stat.out_free   = !rsp_valid_reg || rsp_ready;
        stat.ir         = ir_reg;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_pc     = rsp_pc_reg;
    assign rsp_data   = rsp_data_reg;

endmodule

`default_nettype wire

// ----- design/mcs_controller.sv -----
// mcs_controller: command sequencer and instruction decode state machine
// depends on mcs_pkg; drives mcs_datapath through dp_cmd_t
`default_nettype none

module mcs_controller import mcs_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_RD_LO   = 5'd2;
    localparam logic [4:0] S_RD_HI   = 5'd3;
    localparam logic [4:0] S_RD_END  = 5'd4;
    localparam logic [4:0] S_FETCHED = 5'd5;
    localparam logic [4:0] S_DECODE  = 5'd6;
    localparam logic [4:0] S_OPND    = 5'd7;
    localparam logic [4:0] S_DEFER   = 5'd8;
    localparam logic [4:0] S_AFTER   = 5'd9;
    localparam logic [4:0] S_VAL     = 5'd10;
    localparam logic [4:0] S_NEXT    = 5'd11;
    localparam logic [4:0] S_WB_LO   = 5'd12;
    localparam logic [4:0] S_WB_HI   = 5'd13;
    localparam logic [4:0] S_COMMIT  = 5'd14;
    localparam logic [4:0] S_FAULT   = 5'd15;
    localparam logic [4:0] S_RESP    = 5'd16;

    localparam logic [2:0] CLS_MOV  = 3'd0;
    localparam logic [2:0] CLS_ADD  = 3'd1;
    localparam logic [2:0] CLS_HALT = 3'd2;
    localparam logic [2:0] CLS_CLR  = 3'd3;
    localparam logic [2:0] CLS_NOOP = 3'd4;
    localparam logic [2:0] CLS_SOB  = 3'd5;
    localparam logic [2:0] CLS_MOVB = 3'd6;

    logic [4:0] state_reg, state_next, ret_reg, ret_next;
    logic [2:0] status_reg, status_next, cls_reg, cls_next, cls_dec, mode;
    logic [1:0] rd_sel_reg, rd_sel_next;
    logic       rd_word_reg, rd_word_next, dst_reg, dst_next;
    logic       byte_op, need_val;

    // instruction class in decode priority order
    function automatic logic [2:0] decode_class(input word_t w);
        logic [2:0] c;
        if ((w & 16'o170000) == 16'o010000)
            c = CLS_MOV;
        else if ((w & 16'o170000) == 16'o060000)
            c = CLS_ADD;
        else if (w == 16'o000000)
            c = CLS_HALT;
        else if ((w & 16'o177700) == 16'o005000)
            c = CLS_CLR;
        else if ((w & 16'o170000) == 16'o000000)
            c = CLS_NOOP;
        else if ((w & 16'o177000) == 16'o077000)
            c = CLS_SOB;
        else if ((w & 16'o170000) == 16'o110000)
            c = CLS_MOVB;
        else
            c = CLS_NOOP;
        return c;
    endfunction

    // next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        status_next  = status_reg;
        rd_sel_next  = rd_sel_reg;
        rd_word_next = rd_word_reg;
        dst_next     = dst_reg;
        cls_next     = cls_reg;
        cls_dec      = decode_class(stat.ir);
        byte_op      = (cls_reg == CLS_MOVB);
        need_val     = !dst_reg || (cls_reg == CLS_ADD);
        mode         = dst_reg ? stat.ir[5:3] : stat.ir[11:9];

        cmd.op      = OP_NONE;
        cmd.dst     = dst_reg;
        cmd.byte_op = byte_op;
        cmd.alu     = (cls_reg == CLS_ADD) ? ALU_ADD :
                      (cls_reg == CLS_CLR) ? ALU_CLR : ALU_MOV;
        cmd.status  = status_reg;
        cmd.rd_sel  = rd_sel_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                status_next = ST_OK;
                rd_sel_next = RSEL_ZERO;
                state_next  = S_RESP;
                case (stat.req_cmd)
                    CMD_LOAD:  cmd.op = OP_LOAD;
                    CMD_EXEC:
                    begin
                        if (stat.halted)
                            status_next = ST_HALTED;
                        else
                        begin
                            cmd.op       = OP_COPY;
                            rd_word_next = 1'b1;
                            ret_next     = S_FETCHED;
                            state_next   = S_RD_LO;
                        end
                    end
                    CMD_RDREG: rd_sel_next = RSEL_REG;
                    CMD_RDMEM:
                    begin
                        if (stat.req_odd)
                            status_next = ST_ODD;
                        else
                        begin
                            cmd.op       = OP_MAR_REQ;
                            rd_word_next = 1'b1;
                            rd_sel_next  = RSEL_MDR;
                            ret_next     = S_RESP;
                            state_next   = S_RD_LO;
                        end
                    end
                    CMD_START: cmd.op = OP_START;
                    default: ;
                endcase
            end
            S_RD_LO:
            begin
                if (rd_word_reg && stat.mar_odd)
                begin
                    status_next = ST_ODD;
                    state_next  = S_FAULT;
                end
                else
                begin
                    cmd.op     = OP_RD_LO;
                    state_next = S_RD_HI;
                end
            end
            S_RD_HI:
            begin
                cmd.op     = OP_RD_HI;
                state_next = S_RD_END;
            end
            S_RD_END:
            begin
                cmd.op     = OP_RD_END;
                state_next = ret_reg;
            end
            S_FETCHED:
            begin
                cmd.op     = OP_FETCH;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cls_next = cls_dec;
                case (cls_dec)
                    CLS_MOV, CLS_ADD, CLS_MOVB:
                    begin
                        dst_next   = 1'b0;
                        state_next = S_OPND;
                    end
                    CLS_CLR:
                    begin
                        dst_next   = 1'b1;
                        state_next = S_OPND;
                    end
                    CLS_HALT:
                    begin
                        cmd.op      = OP_HALT;
                        status_next = ST_HALT;
                        state_next  = S_COMMIT;
                    end
                    CLS_SOB:
                    begin
                        cmd.op     = OP_SOB;
                        state_next = S_COMMIT;
                    end
                    default:
                    begin
                        status_next = ST_NOOP;
                        state_next  = S_COMMIT;
                    end
                endcase
            end
            S_OPND:
            begin
                if (mode == 3'd6 || mode == 3'd7)
                begin
                    status_next = ST_MODE;
                    state_next  = S_FAULT;
                end
                else
                begin
                    cmd.op = OP_OPND;
                    case (mode)
                        3'd0: state_next = S_NEXT;
                        3'd3, 3'd5:
                        begin
                            rd_word_next = 1'b1;
                            ret_next     = S_DEFER;
                            state_next   = S_RD_LO;
                        end
                        default: state_next = S_AFTER;
                    endcase
                end
            end
            S_DEFER:
            begin
                cmd.op     = OP_DEFER;
                state_next = S_AFTER;
            end
            S_AFTER:
            begin
                if (need_val)
                begin
                    rd_word_next = !byte_op;
                    ret_next     = S_VAL;
                    state_next   = S_RD_LO;
                end
                else
                    state_next = S_NEXT;
            end
            S_VAL:
            begin
                cmd.op     = OP_SETVAL;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (dst_reg)
                    state_next = S_WB_LO;
                else
                begin
                    dst_next   = 1'b1;
                    state_next = S_OPND;
                end
            end
            S_WB_LO:
            begin
                if (!stat.dst_in_reg && !byte_op && stat.mar_odd)
                begin
                    status_next = ST_ODD;
                    state_next  = S_FAULT;
                end
                else
                begin
                    cmd.op     = OP_WB_LO;
                    state_next = (stat.dst_in_reg || byte_op) ? S_COMMIT : S_WB_HI;
                end
            end
            S_WB_HI:
            begin
                cmd.op     = OP_WB_HI;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = S_RESP;
            end
            S_FAULT:
            begin
                cmd.op     = OP_HALT;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_RESP;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            status_reg  <= ST_OK;
            rd_sel_reg  <= RSEL_ZERO;
            rd_word_reg <= 1'b0;
            dst_reg     <= 1'b0;
            cls_reg     <= CLS_NOOP;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            status_reg  <= status_next;
            rd_sel_reg  <= rd_sel_next;
            rd_word_reg <= rd_word_next;
            dst_reg     <= dst_next;
            cls_reg     <= cls_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // an accepted request is dispatched in the next cycle
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DISP))
        else $error("request not dispatched");

    // a fault always carries a fault status
    a_fault_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FAULT) |-> (status_reg == ST_ODD || status_reg == ST_MODE))
        else $error("fault without fault status");

    // the upper byte of a word write is only written when the word address is even
    a_wb_even: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WB_HI) |-> !stat.mar_odd)
        else $error("word write at odd address");

    // a response is issued once the output register is free
    a_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("response stuck");

endmodule

`default_nettype wire
